### rtl/calendar_date_add_days_macros.svh
// assertion macros for the date adder checker
`ifndef CALENDAR_DATE_ADD_DAYS_MACROS_SVH
`define CALENDAR_DATE_ADD_DAYS_MACROS_SVH

// same-cycle implication
`define CDAD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date adder assertion failed");

// next-cycle implication
`define CDAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date adder assertion failed");

`endif

### rtl/cdad_pkg.sv
// shared types, constants and calendar functions of the date adder
`default_nettype none

package cdad_pkg;

    localparam int YEAR_W  = 12;
    localparam int RYEAR_W = 13;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 14;
    localparam int CFG_DATA_W = 14;

    localparam logic [YEAR_W-1:0]  YEAR_SPAN     = 12'd100;
    localparam logic [YEAR_W-1:0]  RESET_CUR_YEAR = 12'd2021;
    localparam logic [COUNT_W-1:0] RESET_MAX_DAYS = 14'd10000;
    localparam logic [COUNT_W-1:0] LEAP_CYCLE    = 14'd400;
    localparam logic [YEAR_W-1:0]  LEAP_CYCLE_LAST = 12'd399;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic {
        CFG_LATEST_YEAR = 1'b0,
        CFG_MAX_DAYS    = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_DATE  = 2'd1,
        STATUS_BAD_COUNT = 2'd2
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] a;
        logic [COUNT_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] diff;
        logic               borrow;
    } alu_rsp_t;

    // leap test on the year reduced modulo 400
    function automatic logic is_leap(input logic [8:0] ymod);
        logic century;
        century = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### rtl/cdad_if.sv
// valid/ready channel interfaces of the date adder
`default_nettype none

interface cdad_req_if
    import cdad_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [YEAR_W-1:0]     start_year;
    logic [MONTH_W-1:0]    start_month;
    logic [DAY_W-1:0]      start_day;
    logic [COUNT_W-1:0]    day_count;

    modport source (output valid, start_year, start_month, start_day, day_count,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, day_count,
                    output ready);
endinterface

interface cdad_rsp_if
    import cdad_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [RYEAR_W-1:0]    result_year;
    logic [MONTH_W-1:0]    result_month;
    logic [DAY_W-1:0]      result_day;
    logic [1:0]            status;

    modport source (output valid, result_year, result_month, result_day, status,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, status,
                    output ready);
endinterface

interface cdad_cfg_if
    import cdad_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/cdad_alu.sv
// shared subtract and compare unit of the date adder
`default_nettype none

module cdad_alu
    import cdad_pkg::*;
(
    input  alu_req_t op,
    output alu_rsp_t res
);

    logic [COUNT_W:0] wide;

    assign wide       = {1'b0, op.a} - {1'b0, op.b};
    assign res.diff   = wide[COUNT_W-1:0];
    assign res.borrow = wide[COUNT_W];

endmodule

`default_nettype wire

### rtl/calendar_date_add_days.sv
// steps: S_IDLE takes the request, S_MOD reduces the year modulo 400 and
// S_CHECK checks the date and count, then S_STEP crosses one month per step
// until the count ends; S_MOD and S_STEP share the one subtractor, and S_CHECK
// and S_STEP wait while the result slot is full; one request at a time is taken
// reset: async active low, config back to latest year 2021 and max_days 10000
// top level of the Gregorian date adder
`default_nettype none

module calendar_date_add_days
    import cdad_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    cdad_req_if.sink   req,
    cdad_rsp_if.source rsp,
    cdad_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_STEP
    } state_t;

    state_t               state_reg, state_next;
    logic [RYEAR_W-1:0]   yr_reg, yr_next;
    logic [MONTH_W-1:0]   mon_reg, mon_next;
    logic [DAY_W-1:0]     day_reg, day_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [YEAR_W-1:0]    mod_reg, mod_next;
    logic [YEAR_W-1:0]    cur_year_reg, cur_year_next;
    logic [COUNT_W-1:0]   max_days_reg, max_days_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RYEAR_W-1:0]   out_year_reg, out_year_next;
    logic [MONTH_W-1:0]   out_month_reg, out_month_next;
    logic [DAY_W-1:0]     out_day_reg, out_day_next;
    status_t              out_status_reg, out_status_next;

    alu_req_t             alu_op;
    alu_rsp_t             alu_res;
    logic                 leap;
    logic [DAY_W-1:0]     len;
    logic [DAY_W-1:0]     left;
    logic [YEAR_W-1:0]    low_year;
    logic                 date_ok;
    logic                 slot_free;

    cdad_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    assign leap      = is_leap(mod_reg[8:0]);
    assign len       = month_len(mon_reg, leap);
    assign left      = len - day_reg;
    assign low_year  = (cur_year_reg >= YEAR_SPAN) ? (cur_year_reg - YEAR_SPAN) : '0;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign date_ok   = (yr_reg[YEAR_W-1:0] <= cur_year_reg) && (yr_reg[YEAR_W-1:0] >= low_year)
                       && (mon_reg >= MONTH_JAN) && (mon_reg <= MONTH_DEC)
                       && (day_reg != '0) && (day_reg <= len);

    always_comb
    begin
        if (state_reg == S_MOD)
        begin
            alu_op.a = {{(COUNT_W-YEAR_W){1'b0}}, mod_reg};
            alu_op.b = LEAP_CYCLE;
        end
        else
        begin
            alu_op.a = rem_reg;
            alu_op.b = {{(COUNT_W-DAY_W){1'b0}}, left} + {{(COUNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        yr_next         = yr_reg;
        mon_next        = mon_reg;
        day_next        = day_reg;
        rem_next        = rem_reg;
        mod_next        = mod_reg;
        cur_year_next   = cur_year_reg;
        max_days_next   = max_days_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_year_next   = out_year_reg;
        out_month_next  = out_month_reg;
        out_day_next    = out_day_reg;
        out_status_next = out_status_reg;

        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_LATEST_YEAR: cur_year_next = cfg.data[YEAR_W-1:0];
                CFG_MAX_DAYS:    max_days_next = cfg.data;
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    yr_next    = {1'b0, req.start_year};
                    mon_next   = req.start_month;
                    day_next   = req.start_day;
                    rem_next   = req.day_count;
                    mod_next   = req.start_year;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (!alu_res.borrow)
                    mod_next = alu_res.diff[YEAR_W-1:0];
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!date_ok || (rem_reg > max_days_reg))
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_year_next   = '0;
                        out_month_next  = '0;
                        out_day_next    = '0;
                        out_status_next = date_ok ? STATUS_BAD_COUNT : STATUS_BAD_DATE;
                        state_next      = S_IDLE;
                    end
                end
                else
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (alu_res.borrow)
                begin
                    // count ends inside this month
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_year_next   = yr_reg;
                        out_month_next  = mon_reg;
                        out_day_next    = day_reg + rem_reg[DAY_W-1:0];
                        out_status_next = STATUS_OK;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    rem_next = alu_res.diff;
                    day_next = {{(DAY_W-1){1'b0}}, 1'b1};
                    if (mon_reg == MONTH_DEC)
                    begin
                        mon_next = MONTH_JAN;
                        yr_next  = yr_reg + {{(RYEAR_W-1){1'b0}}, 1'b1};
                        mod_next = (mod_reg == LEAP_CYCLE_LAST) ? '0
                                   : mod_reg + {{(YEAR_W-1){1'b0}}, 1'b1};
                    end
                    else
                        mon_next = mon_reg + {{(MONTH_W-1){1'b0}}, 1'b1};
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            yr_reg         <= '0;
            mon_reg        <= '0;
            day_reg        <= '0;
            rem_reg        <= '0;
            mod_reg        <= '0;
            cur_year_reg   <= RESET_CUR_YEAR;
            max_days_reg   <= RESET_MAX_DAYS;
            out_valid_reg  <= 1'b0;
            out_year_reg   <= '0;
            out_month_reg  <= '0;
            out_day_reg    <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            yr_reg         <= yr_next;
            mon_reg        <= mon_next;
            day_reg        <= day_next;
            rem_reg        <= rem_next;
            mod_reg        <= mod_next;
            cur_year_reg   <= cur_year_next;
            max_days_reg   <= max_days_next;
            out_valid_reg  <= out_valid_next;
            out_year_reg   <= out_year_next;
            out_month_reg  <= out_month_next;
            out_day_reg    <= out_day_next;
            out_status_reg <= out_status_next;
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_year  = out_year_reg;
    assign rsp.result_month = out_month_reg;
    assign rsp.result_day   = out_day_reg;
    assign rsp.status       = out_status_reg;

endmodule

`default_nettype wire

### rtl/cdad_checker.sv
// port-level assertions of the date adder and their bind
`default_nettype none

`include "calendar_date_add_days_macros.svh"

module cdad_checker
    import cdad_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_ready,
    input wire                 out_valid,
    input wire                 out_ready,
    input wire [RYEAR_W-1:0]   out_year,
    input wire [MONTH_W-1:0]   out_month,
    input wire [DAY_W-1:0]     out_day,
    input wire [1:0]           out_status
);

    logic                                  date_zero;
    logic                                  date_real;
    logic [RYEAR_W+MONTH_W+DAY_W+1:0]      out_fields;

    assign date_zero  = (out_year == '0) && (out_month == '0) && (out_day == '0);
    assign date_real  = (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC)
                        && (out_day != '0);
    assign out_fields = {out_year, out_month, out_day, out_status};

    // one request at a time
    `CDAD_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

    // errors carry an all-zero date
    `CDAD_ASSERT_SAME(a_err_zero, out_valid && (out_status != STATUS_OK), date_zero)

    // a good result has a month in 1..12 and a nonzero day
    `CDAD_ASSERT_SAME(a_ok_date, out_valid && (out_status == STATUS_OK), date_real)

    // stalled result holds
    `CDAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_year   (rsp.result_year),
    .out_month  (rsp.result_month),
    .out_day    (rsp.result_day),
    .out_status (rsp.status)
);

`default_nettype wire
